// ===== sv/hiwa_pkg.sv =====
// Shared types and constants for the homography inverse warp address unit.
// No dependencies; used by homography_inverse_warp_address_unit.
`default_nettype none
package hiwa_pkg;
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = 13;
   localparam int PROD_BITS  = 45;   // 32-bit coefficient times 13-bit signed coordinate
   localparam int SUM_BITS   = 47;
   localparam int DIV_BITS   = 48;
   localparam int WIDE_BITS  = DIV_BITS + COORD_BITS;
   localparam int LATENCY    = COORD_BITS + 5;

   typedef enum logic [2:0] {
      REG_ROW_X  = 3'd0,
      REG_ROW_Y  = 3'd1,
      REG_ROW_W  = 3'd2,
      REG_TRANS  = 3'd3,
      REG_PERSP  = 3'd4,
      REG_WIDTH  = 3'd5,
      REG_HEIGHT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                  vld;
      logic [DIV_BITS-1:0]   rem;
      logic [DIV_BITS-1:0]   dvs;
      logic [COORD_BITS-1:0] quo;
      logic                  neg;
      logic                  bad;
   } div_type;
endpackage
`default_nettype wire

// ===== sv/homography_inverse_warp_address_unit.sv =====
// Top level of the homography inverse warp address unit: matrix products,
// rounding divider pipeline and bounds check. Depends on hiwa_pkg.
//
// The path from start to rsp_valid runs through three arithmetic stages, one
// overflow stage, one restoring-division stage per quotient bit and the
// output register. Throughput is one word per cycle.
// busy is never raised; results cannot be stalled. Synchronous reset clears
// all valid bits and loads the register defaults (perspective on, 4096x4096).
`default_nettype none
module homography_inverse_warp_address_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_dest_x,
   input  wire logic [11:0] req_dest_y,
   output logic             rsp_valid,
   output logic [11:0]      rsp_source_x,
   output logic [11:0]      rsp_source_y,
   output logic             rsp_inside_res,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   localparam int CB = hiwa_pkg::COORD_BITS;
   localparam int PB = hiwa_pkg::PROD_BITS;
   localparam int SB = hiwa_pkg::SUM_BITS;
   localparam int DB = hiwa_pkg::DIV_BITS;
   localparam int WB = hiwa_pkg::WIDE_BITS;
   localparam int ZB = hiwa_pkg::SIZE_BITS;

   logic [63:0]   row_x_ff, row_y_ff, row_w_ff, trans_ff;
   logic          persp_ff;
   logic [ZB-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= '0;
         row_y_ff  <= '0;
         row_w_ff  <= '0;
         trans_ff  <= '0;
         persp_ff  <= 1'b1;
         width_ff  <= ZB'(4096);
         height_ff <= ZB'(4096);
      end else if (csr_we) begin
         case (hiwa_pkg::reg_index_type'(csr_index))
            hiwa_pkg::REG_ROW_X:  row_x_ff  <= csr_wdata;
            hiwa_pkg::REG_ROW_Y:  row_y_ff  <= csr_wdata;
            hiwa_pkg::REG_ROW_W:  row_w_ff  <= csr_wdata;
            hiwa_pkg::REG_TRANS:  trans_ff  <= csr_wdata;
            hiwa_pkg::REG_PERSP:  persp_ff  <= csr_wdata[0];
            hiwa_pkg::REG_WIDTH:  width_ff  <= csr_wdata[ZB-1:0];
            hiwa_pkg::REG_HEIGHT: height_ff <= csr_wdata[ZB-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 1: six products.
   logic                 s1_vld_ff;
   logic signed [PB-1:0] p_ff [0:5];
   logic signed [CB:0]   xs, ys;

   assign xs = signed'({1'b0, req_dest_x[CB-1:0]});
   assign ys = signed'({1'b0, req_dest_y[CB-1:0]});

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= start;
      p_ff[0] <= PB'(signed'(row_x_ff[31:0])  * xs);
      p_ff[1] <= PB'(signed'(row_x_ff[63:32]) * ys);
      p_ff[2] <= PB'(signed'(row_y_ff[31:0])  * xs);
      p_ff[3] <= PB'(signed'(row_y_ff[63:32]) * ys);
      p_ff[4] <= PB'(signed'(row_w_ff[31:0])  * xs);
      p_ff[5] <= PB'(signed'(row_w_ff[63:32]) * ys);
   end

   // Stage 2: row sums in Q.24.
   logic                 s2_vld_ff;
   logic signed [SB-1:0] nx_ff, ny_ff, nw_ff;
   logic signed [SB-1:0] tx_in, ty_in;

   assign tx_in = SB'(signed'(trans_ff[31:0]))  <<< 12;
   assign ty_in = SB'(signed'(trans_ff[63:32])) <<< 12;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      nx_ff <= SB'(p_ff[0]) + SB'(p_ff[1]) + tx_in;
      ny_ff <= SB'(p_ff[2]) + SB'(p_ff[3]) + ty_in;
      nw_ff <= SB'(p_ff[4]) + SB'(p_ff[5]) + (SB'(1) <<< 24);
   end

   // Stage 3: rounding dividend and divisor for both coordinates.
   // Perspective: floor((2|N|+|W|)/(2|W|)); affine: floor((|N|+2^23)/2^24).
   hiwa_pkg::div_type s3x_in, s3y_in, s3x_ff, s3y_ff;
   logic [SB-1:0] ax, ay, aw;

   assign ax = nx_ff[SB-1] ? SB'(-nx_ff) : SB'(nx_ff);
   assign ay = ny_ff[SB-1] ? SB'(-ny_ff) : SB'(ny_ff);
   assign aw = nw_ff[SB-1] ? SB'(-nw_ff) : SB'(nw_ff);

   always_comb begin
      s3x_in = '0;
      s3y_in = '0;
      s3x_in.vld = s2_vld_ff;
      s3y_in.vld = s2_vld_ff;
      if (persp_ff) begin
         s3x_in.rem = {ax, 1'b0} + DB'(aw);
         s3y_in.rem = {ay, 1'b0} + DB'(aw);
         s3x_in.dvs = {aw, 1'b0};
         s3y_in.dvs = {aw, 1'b0};
         s3x_in.neg = nx_ff[SB-1] ^ nw_ff[SB-1];
         s3y_in.neg = ny_ff[SB-1] ^ nw_ff[SB-1];
         s3x_in.bad = (nw_ff == '0);
         s3y_in.bad = (nw_ff == '0);
      end else begin
         s3x_in.rem = DB'(ax) + (DB'(1) << 23);
         s3y_in.rem = DB'(ay) + (DB'(1) << 23);
         s3x_in.dvs = DB'(1) << 24;
         s3y_in.dvs = DB'(1) << 24;
         s3x_in.neg = nx_ff[SB-1];
         s3y_in.neg = ny_ff[SB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3x_ff.vld <= 1'b0;
         s3y_ff.vld <= 1'b0;
      end else begin
         s3x_ff.vld <= s3x_in.vld;
         s3y_ff.vld <= s3y_in.vld;
      end
      s3x_ff.rem <= s3x_in.rem;  s3y_ff.rem <= s3y_in.rem;
      s3x_ff.dvs <= s3x_in.dvs;  s3y_ff.dvs <= s3y_in.dvs;
      s3x_ff.quo <= s3x_in.quo;  s3y_ff.quo <= s3y_in.quo;
      s3x_ff.neg <= s3x_in.neg;  s3y_ff.neg <= s3y_in.neg;
      s3x_ff.bad <= s3x_in.bad;  s3y_ff.bad <= s3y_in.bad;
   end

   // Division pipeline. Entry 0 flags quotients of 2^CB or more; entry k+1
   // settles quotient bit CB-1-k by one compare and subtract.
   hiwa_pkg::div_type dx_ff [0:CB];
   hiwa_pkg::div_type dy_ff [0:CB];
   hiwa_pkg::div_type dx_in [0:CB];
   hiwa_pkg::div_type dy_in [0:CB];

   always_comb begin
      dx_in[0] = s3x_ff;
      dy_in[0] = s3y_ff;
      if ({{CB{1'b0}}, s3x_ff.rem} >= ({{CB{1'b0}}, s3x_ff.dvs} << CB)) dx_in[0].bad = 1'b1;
      if ({{CB{1'b0}}, s3y_ff.rem} >= ({{CB{1'b0}}, s3y_ff.dvs} << CB)) dy_in[0].bad = 1'b1;
   end

   for (genvar k = 0; k < CB; k++) begin : g_div
      localparam int SH = CB - 1 - k;
      logic [WB-1:0] sdx, sdy;
      assign sdx = {{CB{1'b0}}, dx_ff[k].dvs} << SH;
      assign sdy = {{CB{1'b0}}, dy_ff[k].dvs} << SH;
      always_comb begin
         dx_in[k+1] = dx_ff[k];
         dy_in[k+1] = dy_ff[k];
         if ({{CB{1'b0}}, dx_ff[k].rem} >= sdx) begin
            dx_in[k+1].rem     = DB'({{CB{1'b0}}, dx_ff[k].rem} - sdx);
            dx_in[k+1].quo[SH] = 1'b1;
         end
         if ({{CB{1'b0}}, dy_ff[k].rem} >= sdy) begin
            dy_in[k+1].rem     = DB'({{CB{1'b0}}, dy_ff[k].rem} - sdy);
            dy_in[k+1].quo[SH] = 1'b1;
         end
      end
   end

   for (genvar k = 0; k <= CB; k++) begin : g_dreg
      always_ff @(posedge clock) begin
         if (reset) begin
            dx_ff[k].vld <= 1'b0;
            dy_ff[k].vld <= 1'b0;
         end else begin
            dx_ff[k].vld <= dx_in[k].vld;
            dy_ff[k].vld <= dy_in[k].vld;
         end
         dx_ff[k].rem <= dx_in[k].rem;  dy_ff[k].rem <= dy_in[k].rem;
         dx_ff[k].dvs <= dx_in[k].dvs;  dy_ff[k].dvs <= dy_in[k].dvs;
         dx_ff[k].quo <= dx_in[k].quo;  dy_ff[k].quo <= dy_in[k].quo;
         dx_ff[k].neg <= dx_in[k].neg;  dy_ff[k].neg <= dy_in[k].neg;
         dx_ff[k].bad <= dx_in[k].bad;  dy_ff[k].bad <= dy_in[k].bad;
      end
   end

   // Output stage: bounds check against the saturated source size.
   logic [ZB-1:0] wlim, hlim;
   logic          inside_in;
   hiwa_pkg::div_type fx, fy;

   assign fx   = dx_ff[CB];
   assign fy   = dy_ff[CB];
   assign wlim = (width_ff  > (ZB'(1) << CB)) ? (ZB'(1) << CB) : width_ff;
   assign hlim = (height_ff > (ZB'(1) << CB)) ? (ZB'(1) << CB) : height_ff;
   // A negative sign is harmless only when the rounded magnitude is zero.
   assign inside_in = !fx.bad && !fy.bad
                      && !(fx.neg && fx.quo != '0) && !(fy.neg && fy.quo != '0)
                      && (ZB'(fx.quo) < wlim) && (ZB'(fy.quo) < hlim);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= fx.vld;
      rsp_inside_res <= inside_in;
      rsp_source_x   <= inside_in ? fx.quo : '0;
      rsp_source_y   <= inside_in ? fy.quo : '0;
   end

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(hiwa_pkg::LATENCY) rsp_valid)
      else $error("word lost in pipeline");
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      dx_ff[CB].vld == dy_ff[CB].vld)
      else $error("coordinate lanes out of step");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_source_x == '0 && rsp_source_y == '0)
      else $error("outside word carries a coordinate");
   a_inside_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> ZB'(rsp_source_x) < $past(wlim))
      else $error("inside word beyond source width");
`endif
endmodule
`default_nettype wire
